// ===== hdl/gsac_pkg.sv =====
// ----------------------------------------------------------------------------
// gsac_pkg: shared types and constants
// Word formats, operation codes, register indexes and the full-scale decode
// of the grayscale sensor array conditioner.
// ----------------------------------------------------------------------------
package gsac_pkg;

    localparam int SAMPLE_W = 14;
    localparam int FS_W     = 15;
    localparam int SCALE_W  = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Operation codes of an input word
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CAL    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADC_RES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd1;

    // Resolution codes
    localparam logic [1:0] RES_8BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_12BIT = 2'd2;
    localparam logic [1:0] RES_14BIT = 2'd3;

    // Divide by three: q = (n * DIV3_MUL) >> DIV3_SHIFT, exact for n < 2**16
    localparam int DIV3_IN_W = 16;
    localparam int DIV3_MUL_W = 17;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 17'd87382;
    localparam int DIV3_SHIFT = 18;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [2:0]          cal_channel;
        logic [SAMPLE_W-1:0] cal_white;
        logic [SAMPLE_W-1:0] cal_black;
    } gsac_in_t;

    typedef struct packed {
        logic [2:0]          channel;
        logic [SAMPLE_W-1:0] average;
        logic [FS_W-1:0]     normalized;
        logic [7:0]          digital;
        logic                calibrated;
        logic                last_of_scan;
    } gsac_out_t;

    // One calibration entry of a channel position
    typedef struct packed {
        logic [SAMPLE_W-1:0] upper;
        logic [SAMPLE_W-1:0] lower;
        logic [SAMPLE_W-1:0] black;
        logic [SCALE_W-1:0]  scale;
    } gsac_cal_t;

    function automatic logic [FS_W-1:0] full_scale(input logic [1:0] res);
        logic [FS_W-1:0] fs;
        unique case (res)
            RES_8BIT:  fs = 15'd255;
            RES_10BIT: fs = 15'd1024;
            RES_12BIT: fs = 15'd4096;
            RES_14BIT: fs = 15'd16384;
            default:   fs = 15'd16384;
        endcase
        return fs;
    endfunction

endpackage

// ===== hdl/gsac_if.sv =====
// ----------------------------------------------------------------------------
// gsac_if: channel interfaces
// Input, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsac_in_if import gsac_pkg::*; ();
    logic     valid;
    logic     ready;
    gsac_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gsac_out_if import gsac_pkg::*; ();
    logic      valid;
    logic      ready;
    gsac_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gsac_cfg_if import gsac_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gray_sensor_array_conditioner_top.sv =====
// ----------------------------------------------------------------------------
// gray_sensor_array_conditioner_top: grayscale line sensor conditioner
// Averages raw readings per channel, applies hysteresis thresholds and a
// calibrated black offset and scale, and loads per-channel calibration.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per handshake; op selects a raw ADC reading or a
//            calibration load (white/black levels of one position).
//   out_ch : one result word after every READS_PER_CHANNEL readings.
//   cfg_ch : register writes (resolution, reverse order), always ready.
// Sequence:
//   A reading that does not complete a channel is only accumulated. The
//   reading that completes it steps through accept, average multiply plus
//   calibration memory read, threshold compare plus scale multiply, clamp
//   and load into the output register, waiting while it is full. A calibration
//   load runs the bit-serial scale divider (31 steps, one quotient bit each).
// Reset:
//   Clears counters, scan position, digital bits and the calibrated flag;
//   per-entry valid bits make every calibration entry read as zero.
// Stall:
//   The output register holds a result until taken; the block keeps taking
//   input words meanwhile and waits only when a new result finds it full.
// ----------------------------------------------------------------------------
module gray_sensor_array_conditioner_top import gsac_pkg::*; #(
    parameter int NUM_CHANNELS      = 8,
    parameter int READS_PER_CHANNEL = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    gsac_in_if.sink    in_ch,
    gsac_out_if.source out_ch,
    gsac_cfg_if.sink   cfg_ch
);

    // Widths derived from the channel and reading counts
    localparam int POS_W  = $clog2(NUM_CHANNELS);
    localparam int PX_W   = (POS_W > 3) ? POS_W : 3;
    localparam int DIG_W  = (NUM_CHANNELS > 8) ? NUM_CHANNELS : 8;
    localparam int RD_LOG = $clog2(READS_PER_CHANNEL);
    localparam int CNT_W  = (RD_LOG > 0) ? RD_LOG : 1;
    localparam int SUM_W  = SAMPLE_W + RD_LOG;
    // Average by reciprocal: floor(sum / R) = (sum * AVG_MUL) >> AVG_SHIFT
    localparam int AVG_SHIFT = SUM_W + RD_LOG;
    localparam int AVG_PROD_W = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] AVG_MUL = (SUM_W + 1)'(
        ((64'd1 << AVG_SHIFT) + 64'(READS_PER_CHANNEL) - 64'd1)
        / 64'(READS_PER_CHANNEL));
    localparam int DIV_STEPS = SCALE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int NPROD_W = SAMPLE_W + SCALE_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AVG  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_THR  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [2:0]       state_reg,   state_next;
    logic [1:0]       res_reg,     res_next;
    logic             rev_reg,     rev_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [POS_W-1:0] scan_reg,    scan_next;
    logic [SUM_W-1:0] sum_reg,     sum_next;
    logic [DIG_W-1:0] dig_reg,     dig_next;
    logic             calflag_reg, calflag_next;
    logic [NUM_CHANNELS-1:0] ent_valid_reg, ent_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] avg_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                last_reg;
    logic                below_reg;
    logic [NPROD_W-1:0]  nprod_reg;
    gsac_cal_t           rd_data_reg;
    logic                rd_valid_reg;
    gsac_out_t           out_data_reg;
    // calibration path
    logic [SAMPLE_W-1:0] w_reg, b_reg;
    logic [POS_W-1:0]    cidx_reg;
    logic [FS_W-1:0]     cfs_reg;
    logic [SAMPLE_W-1:0] up_reg, lo_reg;
    logic [SAMPLE_W-1:0] dvs_reg;
    logic [SAMPLE_W:0]   rem_reg;
    logic [SCALE_W-1:0]  quo_reg;

    gsac_cal_t cal_mem [NUM_CHANNELS];

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                in_acc;
    logic                cfg_acc;
    logic                rd_last;
    logic                scan_last;
    logic [POS_W-1:0]    pos_cur;
    logic [PX_W-1:0]     cal_ext;
    logic [PX_W-1:0]     pos_ext;
    logic                cal_in_range;
    logic                swap;
    logic [AVG_PROD_W-1:0] avg_prod;
    gsac_cal_t           ent;
    logic [SAMPLE_W-1:0] ndiff;
    logic [DIV3_IN_W-1:0] up_sum, lo_sum;
    logic [DIV3_IN_W+DIV3_MUL_W-1:0] up_prod, lo_prod;
    logic [SAMPLE_W:0]   rem_sh;
    logic                rem_ge;
    logic [FS_W-1:0]     fs_now;
    logic [NPROD_W-17:0] nscaled;
    logic [FS_W-1:0]     norm;
    logic                out_free;

    assign in_acc   = in_ch.valid & in_ch.ready;
    assign cfg_acc  = cfg_ch.valid & cfg_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign out_free = ~out_valid_reg | out_ch.ready;

    assign rd_last   = (cnt_reg == CNT_W'(READS_PER_CHANNEL - 1));
    assign scan_last = (scan_reg == POS_W'(NUM_CHANNELS - 1));
    assign pos_cur   = rev_reg ? (POS_W'(NUM_CHANNELS - 1) - scan_reg) : scan_reg;

    assign cal_ext      = PX_W'(in_ch.data.cal_channel);
    assign cal_in_range = (32'(in_ch.data.cal_channel) < NUM_CHANNELS);
    assign swap         = (in_ch.data.cal_black >= in_ch.data.cal_white);

    assign avg_prod = AVG_PROD_W'(sum_reg) * AVG_PROD_W'(AVG_MUL);

    // Unwritten entries read as the reset value
    assign ent   = rd_valid_reg ? rd_data_reg : '0;
    assign ndiff = avg_reg - ent.black;

    assign up_sum  = {1'b0, w_reg, 1'b0} + DIV3_IN_W'(b_reg);
    assign lo_sum  = DIV3_IN_W'(w_reg) + {1'b0, b_reg, 1'b0};
    assign up_prod = (DIV3_IN_W + DIV3_MUL_W)'(up_sum) * (DIV3_IN_W + DIV3_MUL_W)'(DIV3_MUL);
    assign lo_prod = (DIV3_IN_W + DIV3_MUL_W)'(lo_sum) * (DIV3_IN_W + DIV3_MUL_W)'(DIV3_MUL);

    // One restoring divider step per cycle
    assign rem_sh = {rem_reg[SAMPLE_W-1:0], quo_reg[SCALE_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    assign fs_now  = full_scale(res_reg);
    assign nscaled = nprod_reg[NPROD_W-1:16];
    always_comb
    begin
        if (below_reg)
            norm = '0;
        else if (nscaled > (NPROD_W - 16)'(fs_now))
            norm = fs_now;
        else
            norm = nscaled[FS_W-1:0];
    end

    assign pos_ext = PX_W'(pos_reg);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        rev_next       = rev_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        sum_next       = sum_reg;
        dig_next       = dig_reg;
        calflag_next   = calflag_reg;
        ent_valid_next = ent_valid_reg;
        out_valid_next = out_valid_reg;
        dcnt_next      = dcnt_reg;

        if (cfg_acc) begin
            unique case (cfg_ch.index)
                REG_ADC_RES: res_next = cfg_ch.data[1:0];
                REG_REVERSE: rev_next = cfg_ch.data[0];
                default: ;
            endcase
        end

        // Drop the result once the sink takes it
        if (out_ch.valid && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc) begin
                    if (in_ch.data.op == OP_SAMPLE) begin
                        sum_next = sum_reg + SUM_W'(in_ch.data.sample);
                        if (rd_last) begin
                            cnt_next   = '0;
                            state_next = ST_AVG;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else if (cal_in_range) begin
                        state_next = ST_THR;
                    end
                end
            end
            ST_AVG:
            begin
                // Average and memory read issue happen together
                sum_next   = '0;
                scan_next  = scan_last ? '0 : scan_reg + 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (avg_reg > ent.upper)
                    dig_next[pos_reg] = 1'b1;
                else if (avg_reg < ent.lower)
                    dig_next[pos_reg] = 1'b0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // Hold until the output register is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_THR:
            begin
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_WR;
            end
            ST_WR:
            begin
                ent_valid_next[cidx_reg] = 1'b1;
                calflag_next             = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            res_reg       <= RES_12BIT;
            rev_reg       <= 1'b0;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            sum_reg       <= '0;
            dig_reg       <= '0;
            calflag_reg   <= 1'b0;
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            rev_reg       <= rev_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            sum_reg       <= sum_next;
            dig_reg       <= dig_next;
            calflag_reg   <= calflag_next;
            ent_valid_reg <= ent_valid_next;
            out_valid_reg <= out_valid_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_AVG) begin
            avg_reg  <= avg_prod[AVG_SHIFT +: SAMPLE_W];
            pos_reg  <= pos_cur;
            last_reg <= scan_last;
        end
        if (state_reg == ST_READ) begin
            below_reg <= (avg_reg < ent.black);
            nprod_reg <= NPROD_W'(ndiff) * NPROD_W'(ent.scale);
        end
        if (state_reg == ST_NORM && out_free) begin
            out_data_reg.channel      <= pos_ext[2:0];
            out_data_reg.average      <= avg_reg;
            out_data_reg.normalized   <= norm;
            out_data_reg.digital      <= dig_reg[7:0];
            out_data_reg.calibrated   <= calflag_reg;
            out_data_reg.last_of_scan <= last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Calibration memory: registered read, single write port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_AVG) begin
            rd_data_reg  <= cal_mem[pos_cur];
            rd_valid_reg <= ent_valid_reg[pos_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WR) begin
            cal_mem[cidx_reg] <= '{upper: up_reg, lower: lo_reg, black: b_reg,
                                   scale: (dvs_reg == '0) ? '0 : quo_reg};
        end
    end

    // ------------------------------------------------------------------
    // Calibration datapath: order levels, thirds, scale divider
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc) begin
            w_reg    <= swap ? in_ch.data.cal_black : in_ch.data.cal_white;
            b_reg    <= swap ? in_ch.data.cal_white : in_ch.data.cal_black;
            cidx_reg <= cal_ext[POS_W-1:0];
            cfs_reg  <= fs_now;
        end
        if (state_reg == ST_THR) begin
            up_reg  <= up_prod[DIV3_SHIFT +: SAMPLE_W];
            lo_reg  <= lo_prod[DIV3_SHIFT +: SAMPLE_W];
            dvs_reg <= w_reg - b_reg;
            rem_reg <= '0;
            quo_reg <= {cfs_reg, 16'd0};
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_reg <= {quo_reg[SCALE_W-2:0], rem_ge};
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the grayscale sensor array conditioner
// Drives raw readings and calibration loads through the input channel,
// predicts each channel result in-line or takes it from the plan, checks
// each result word field by field and in order. Both channel sides idle at
// random; the run steps through several resolution and scan-order settings.
// ----------------------------------------------------------------------------
module tb_top import gsac_pkg::*; ();

    localparam int CLK_PERIOD    = 12;
    localparam int NCH           = 8;
    localparam int READS         = 8;
    localparam int MAX_CODE      = 16383;
    localparam int MAX_GAP       = 18;
    localparam int PHASES        = 8;
    localparam int RANDOM_ITEMS  = 1780;
    // A calibration load keeps the divider busy and emits nothing; wait
    // out any such load before touching the registers.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 10;

    // Indexes with no register behind them; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_RARE} idle_mode_e;

    // One row of the directed plan: a word sent reps times in a row. Where
    // lit is set, the result that the row causes is typed in by hand.
    typedef struct {
        logic op;
        int   sample;
        int   chan;
        int   white;
        int   black;
        int   reps;
        bit   lit;
        int   want_ch;
        int   want_avg;
        int   want_norm;
        int   want_dig;
        int   want_cal;
        int   want_last;
    } plan_row_t;

    localparam int PLAN_ROWS = 5;

    // Directed plan, run from reset values (12-bit scale, forward order):
    //   all-zero readings on an uncalibrated channel: nothing set;
    //   full-code readings on an uncalibrated channel: zero thresholds set
    //     the bit, zero scale keeps normalized at zero;
    //   equal levels on position 2, then readings right at the threshold:
    //     the bit is kept and normalized stays at zero;
    //   black above white on position 7 (the levels get swapped), checked
    //     later by the random part once the scan reaches it.
    plan_row_t plan [PLAN_ROWS] = '{
        '{OP_SAMPLE, 0,        0, 0,    0,        READS, 1'b1,
          0, 0,        0, 8'h00, 0, 0},
        '{OP_SAMPLE, MAX_CODE, 0, 0,    0,        READS, 1'b1,
          1, MAX_CODE, 0, 8'h02, 0, 0},
        '{OP_CAL,    0,        2, 7000, 7000,     1,     1'b0,
          0, 0,        0, 8'h00, 0, 0},
        '{OP_CAL,    0,        7, 0,    MAX_CODE, 1,     1'b0,
          0, 0,        0, 8'h00, 0, 0},
        '{OP_SAMPLE, 7000,     0, 0,    0,        READS, 1'b1,
          2, 7000,     0, 8'h02, 1, 0}
    };

    logic clk = 1'b0;
    logic rst_n;

    gsac_in_if  in_ch ();
    gsac_out_if out_ch ();
    gsac_cfg_if cfg_ch ();

    gray_sensor_array_conditioner_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the conditioner: accumulation, per-position calibration,
    // hysteresis bits and the two registers
    logic [16:0]         acc_sum;
    int                  acc_count;
    int                  scan_pos;
    logic [SAMPLE_W-1:0] thr_hi  [NCH];
    logic [SAMPLE_W-1:0] thr_lo  [NCH];
    logic [SAMPLE_W-1:0] blk_lvl [NCH];
    logic [SCALE_W-1:0]  gain    [NCH];
    logic [7:0]          dig_bits;
    logic                cal_done;
    logic [1:0]          res_sel;
    logic                rev_sel;

    gsac_out_t  pending_results [$];
    int         fault_count = 0;
    int         cycle_count = 0;
    idle_mode_e idle_mode = IDLE_RARE;

    function automatic int span_of(input logic [1:0] res);
        int span;
        case (res)
            RES_8BIT:  span = 255;
            RES_10BIT: span = 1024;
            RES_12BIT: span = 4096;
            default:   span = 16384;
        endcase
        return span;
    endfunction

    function automatic int draw_gap();
        int gap;
        case (idle_mode)
            IDLE_NONE: gap = 0;
            IDLE_FULL: gap = $urandom_range(0, MAX_GAP);
            default:   gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
        endcase
        return gap;
    endfunction

    // Advance the shadow by one accepted input word; return the channel
    // result when the word completes a channel.
    task automatic condition_word(input gsac_in_t w, output bit produced,
                                  output gsac_out_t res);
        int     hi;
        int     lo;
        int     avg;
        int     pos;
        int     blk;
        int     span;
        int     norm;
        bit     last;
        longint prod;
        produced = 1'b0;
        res = '0;
        if (w.op == OP_CAL)
        begin
            // Order the levels so that white sits above black
            hi = w.cal_white;
            lo = w.cal_black;
            if (lo >= hi)
            begin
                hi = w.cal_black;
                lo = w.cal_white;
            end
            thr_hi[w.cal_channel]  = SAMPLE_W'((2 * hi + lo) / 3);
            thr_lo[w.cal_channel]  = SAMPLE_W'((hi + 2 * lo) / 3);
            blk_lvl[w.cal_channel] = SAMPLE_W'(lo);
            if (hi == lo)
                gain[w.cal_channel] = '0;
            else
                gain[w.cal_channel] = SCALE_W'((longint'(span_of(res_sel)) << 16) / (hi - lo));
            cal_done = 1'b1;
        end
        else
        begin
            acc_sum = acc_sum + w.sample;
            acc_count++;
            if (acc_count == READS)
            begin
                avg = int'(acc_sum) / READS;
                acc_sum = '0;
                acc_count = 0;
                last = (scan_pos == NCH - 1);
                pos = rev_sel ? NCH - 1 - scan_pos : scan_pos;
                scan_pos = last ? 0 : scan_pos + 1;

                // Hysteresis: set above the upper threshold, clear below the lower
                if (avg > int'(thr_hi[pos]))
                    dig_bits[pos] = 1'b1;
                else if (avg < int'(thr_lo[pos]))
                    dig_bits[pos] = 1'b0;

                span = span_of(res_sel);
                blk = blk_lvl[pos];
                if (avg < blk)
                    norm = 0;
                else
                begin
                    prod = (longint'(avg - blk) * longint'(gain[pos])) >>> 16;
                    norm = (prod > longint'(span)) ? span : int'(prod);
                end

                produced = 1'b1;
                res.channel      = 3'(pos);
                res.average      = SAMPLE_W'(avg);
                res.normalized   = FS_W'(norm);
                res.digital      = dig_bits;
                res.calibrated   = cal_done;
                res.last_of_scan = last;
            end
        end
    endtask

    // Offer one word after a random gap, hold it until taken, then record
    // the result it causes. Valid stays high when no gap follows.
    task automatic send_word(input gsac_in_t w, input bit lit, input gsac_out_t lit_want);
        int        gap;
        bit        produced;
        gsac_out_t want;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        condition_word(w, produced, want);
        if (produced)
            pending_results.push_back(lit ? lit_want : want);
    endtask

    // Write one register; valid is left high so a following write can go
    // back to back. The caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_ADC_RES: res_sel = val[1:0];
            REG_REVERSE: rev_sel = val[0];
            default: ;
        endcase
    endtask

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: stall at random, take one word, compare it with the
    // oldest expectation.
    initial
    begin : result_sink
        int        gap;
        gsac_out_t got;
        gsac_out_t want;
        out_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            got = out_ch.data;
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("[%0t] result word with none expected: ch %0d avg %0d norm %0d dig %02h cal %0b last %0b",
                             $realtime, got.channel, got.average, got.normalized,
                             got.digital, got.calibrated, got.last_of_scan);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.channel !== want.channel || got.average !== want.average ||
                    got.normalized !== want.normalized || got.digital !== want.digital ||
                    got.calibrated !== want.calibrated || got.last_of_scan !== want.last_of_scan)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("[%0t] mismatch: expected ch %0d avg %0d norm %0d dig %02h cal %0b last %0b",
                                 $realtime, want.channel, want.average, want.normalized,
                                 want.digital, want.calibrated, want.last_of_scan);
                        $display("[%0t]           actual   ch %0d avg %0d norm %0d dig %02h cal %0b last %0b",
                                 $realtime, got.channel, got.average, got.normalized,
                                 got.digital, got.calibrated, got.last_of_scan);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed plan, then random phases with one register
    // setting each.
    initial
    begin : stimulus
        gsac_in_t              word;
        gsac_out_t             lit_want;
        logic [1:0]            res;
        logic                  rev;
        logic [CFG_DATA_W-1:0] cfg_val;
        int                    phase;
        int                    n;
        int                    k;
        int                    pos;
        int                    center;
        int                    spread;
        int                    jitter;
        int                    val;
        int                    w_lvl;
        int                    b_lvl;
        int                    tmp;

        // Hold every input at a known value through reset
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_ADC_RES;
        cfg_ch.data  <= '0;

        acc_sum   = '0;
        acc_count = 0;
        scan_pos  = 0;
        for (k = 0; k < NCH; k++)
        begin
            thr_hi[k]  = '0;
            thr_lo[k]  = '0;
            blk_lvl[k] = '0;
            gain[k]    = '0;
        end
        dig_bits = '0;
        cal_done = 1'b0;
        res_sel  = RES_12BIT;
        rev_sel  = 1'b0;
        center   = 0;
        spread   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            word = '0;
            word.op          = plan[r].op;
            word.sample      = SAMPLE_W'(plan[r].sample);
            word.cal_channel = 3'(plan[r].chan);
            word.cal_white   = SAMPLE_W'(plan[r].white);
            word.cal_black   = SAMPLE_W'(plan[r].black);
            lit_want.channel      = 3'(plan[r].want_ch);
            lit_want.average      = SAMPLE_W'(plan[r].want_avg);
            lit_want.normalized   = FS_W'(plan[r].want_norm);
            lit_want.digital      = 8'(plan[r].want_dig);
            lit_want.calibrated   = 1'(plan[r].want_cal);
            lit_want.last_of_scan = 1'(plan[r].want_last);
            for (k = 0; k < plan[r].reps; k++)
                send_word(word, plan[r].lit, lit_want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Drain the block before changing its setting
            in_ch.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);

            // Cover every resolution and both scan orders first, then roam
            case (phase)
                0:       begin res = RES_8BIT;  rev = 1'b1; end
                1:       begin res = RES_14BIT; rev = 1'b0; end
                2:       begin res = RES_10BIT; rev = 1'b1; end
                3:       begin res = RES_12BIT; rev = 1'b0; end
                default: begin res = 2'($urandom); rev = 1'($urandom); end
            endcase
            cfg_val = 8'($urandom);
            cfg_val[1:0] = res;
            write_reg(REG_ADC_RES, cfg_val);
            cfg_val = 8'($urandom);
            cfg_val[0] = rev;
            write_reg(REG_REVERSE, cfg_val);
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3, 8'($urandom));
            cfg_ch.valid <= 1'b0;

            idle_mode = idle_mode_e'(phase % 3);

            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                // Fill the unused fields with noise
                word.op          = OP_SAMPLE;
                word.sample      = SAMPLE_W'($urandom);
                word.cal_channel = 3'($urandom);
                word.cal_white   = SAMPLE_W'($urandom);
                word.cal_black   = SAMPLE_W'($urandom);

                if ($urandom_range(0, 24) == 0)
                begin
                    word.op = OP_CAL;
                    w_lvl = $urandom_range(0, MAX_CODE);
                    case ($urandom_range(0, 3))
                        0: b_lvl = $urandom_range(0, MAX_CODE);
                        // equal levels: zero scale
                        1: b_lvl = w_lvl;
                        // narrow span: huge scale, drives the clamp
                        2: begin
                            jitter = $urandom_range(1, 4);
                            b_lvl = (w_lvl >= jitter) ? w_lvl - jitter : w_lvl + jitter;
                        end
                        default:
                        begin
                            w_lvl = ($urandom_range(0, 1) == 0) ? 0 : MAX_CODE;
                            b_lvl = MAX_CODE - w_lvl;
                        end
                    endcase
                    // Half the time present the levels the wrong way round
                    if ($urandom_range(0, 1) == 0)
                    begin
                        tmp = w_lvl;
                        w_lvl = b_lvl;
                        b_lvl = tmp;
                    end
                    word.cal_white = SAMPLE_W'(w_lvl);
                    word.cal_black = SAMPLE_W'(b_lvl);
                end
                else
                begin
                    // Pick a level for each channel's group of readings,
                    // half the time around that position's thresholds and black level
                    if (acc_count == 0)
                    begin
                        pos = rev_sel ? NCH - 1 - scan_pos : scan_pos;
                        case ($urandom_range(0, 5))
                            0: center = $urandom_range(0, MAX_CODE);
                            1: center = $urandom_range(0, span_of(res_sel) + 64);
                            2: center = thr_hi[pos];
                            3: center = thr_lo[pos];
                            4: center = blk_lvl[pos];
                            default: center = ($urandom_range(0, 1) == 0) ? 0 : MAX_CODE;
                        endcase
                        spread = ($urandom_range(0, 3) == 0) ? 2000 : 3;
                    end
                    jitter = $urandom_range(0, 2 * spread);
                    val = center + jitter - spread;
                    if (val < 0)
                        val = 0;
                    if (val > MAX_CODE)
                        val = MAX_CODE;
                    word.sample = SAMPLE_W'(val);
                end
                send_word(word, 1'b0, '0);
            end
        end

        // Wait out the tail, then judge
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
